// ===== design/complete_tree_array_store_macros.svh =====
// Assertion macros used by the tree store checker.
`ifndef COMPLETE_TREE_ARRAY_STORE_MACROS_SVH
`define COMPLETE_TREE_ARRAY_STORE_MACROS_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low.
`define CTAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that an expression never holds.
`define CTAS_ASSERT_NEVER(label, expr, msg) \
  `CTAS_ASSERT(label, !(expr), msg)

`endif

// ===== design/ctas_pkg.sv =====
// Types, codes and index helpers for the complete tree array store.
package ctas_pkg;

  localparam int unsigned LevelW = 3;
  localparam int unsigned PosW   = 7;
  localparam int unsigned DataW  = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_PRINT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5,
    ST_LISTED    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_REPL
  } fsm_e;

  // Bit length of a 1-based node number.
  function automatic logic [LevelW-1:0] level_of(input logic [PosW-1:0] node);
    logic [LevelW-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < PosW; i++) begin
      if (node[i]) lvl = LevelW'(i + 1);
    end
    return lvl;
  endfunction

  // 1-based position of a node within its level.
  function automatic logic [PosW-1:0] position_of(input logic [PosW-1:0]   node,
                                                 input logic [LevelW-1:0] lvl);
    logic [PosW-1:0] first;
    first = PosW'(1) << (lvl - LevelW'(1));
    return node - first + PosW'(1);
  endfunction

endpackage

// ===== design/complete_tree_array_store.sv =====
// Complete binary tree store in level order, kept in a single-port-read memory.
// Insert, full and empty words: the result is registered and shows in the cycle after start; busy stays low.
// Search and delete scan one entry per cycle through the memory read port;
//   a delete that hits before the last entry then fetches the last entry to move it into the hole.
// Print shows one listed word per cycle, count words in all.
// Reset clears the entry count and the control state; memory contents stay unknown.
module complete_tree_array_store #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] key_value_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic [2:0]  tree_level_o,
  output logic [6:0]  level_position_o,
  output logic [63:0] data_value_o,
  output logic        was_replaced_o,
  output logic        last_result_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  ctas_pkg::fsm_e state_q, state_d;
  ctas_pkg::op_e  op_q, op_d;
  logic [63:0]     key_q, key_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_m1;
  logic [IdxW-1:0] last_idx;

  logic [63:0]     mem [CAPACITY];
  logic [63:0]     rdata_q;
  logic [IdxW-1:0] raddr;
  logic [IdxW-1:0] waddr;
  logic [63:0]     wdata;
  logic            we;

  logic                    emit;
  ctas_pkg::status_e       emit_status;
  logic [IdxW-1:0]         emit_idx;
  logic                    emit_pos;
  logic [63:0]             emit_data;
  logic                    emit_repl;
  logic                    emit_last;
  logic [ctas_pkg::PosW-1:0]   node;
  logic [ctas_pkg::LevelW-1:0] node_lvl;

  logic is_last;
  logic hit;

  assign count_m1 = count_q - CntW'(1);
  assign last_idx = count_m1[IdxW-1:0];
  assign is_last  = (idx_q == last_idx);
  assign hit      = (rdata_q == key_q);
  assign busy     = (state_q != ctas_pkg::FSM_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    idx_d       = idx_q;
    count_d     = count_q;
    raddr       = idx_q + IdxW'(1);
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata_q;
    emit        = 1'b0;
    emit_status = ctas_pkg::ST_EMPTY;
    emit_idx    = idx_q;
    emit_pos    = 1'b0;
    emit_data   = '0;
    emit_repl   = 1'b0;
    emit_last   = 1'b1;
    case (state_q)
      ctas_pkg::FSM_IDLE: begin
        raddr = '0;
        if (start) begin
          op_d  = ctas_pkg::op_e'(opcode_i);
          key_d = key_value_i;
          idx_d = '0;
          if (ctas_pkg::op_e'(opcode_i) == ctas_pkg::OP_INSERT) begin
            emit = 1'b1;
            if (count_q == CntW'(CAPACITY)) begin
              emit_status = ctas_pkg::ST_FULL;
            end else begin
              we          = 1'b1;
              waddr       = count_q[IdxW-1:0];
              wdata       = key_value_i;
              count_d     = count_q + CntW'(1);
              emit_status = ctas_pkg::ST_INSERTED;
              emit_idx    = count_q[IdxW-1:0];
              emit_pos    = 1'b1;
            end
          end else if (count_q == '0) begin
            emit        = 1'b1;
            emit_status = ctas_pkg::ST_EMPTY;
          end else begin
            state_d = ctas_pkg::FSM_SCAN;
          end
        end
      end
      ctas_pkg::FSM_SCAN: begin
        case (op_q)
          ctas_pkg::OP_PRINT: begin
            emit        = 1'b1;
            emit_status = ctas_pkg::ST_LISTED;
            emit_pos    = 1'b1;
            emit_data   = rdata_q;
            emit_last   = is_last;
            if (is_last) state_d = ctas_pkg::FSM_IDLE;
            else         idx_d   = idx_q + IdxW'(1);
          end
          ctas_pkg::OP_SEARCH: begin
            if (hit) begin
              emit        = 1'b1;
              emit_status = ctas_pkg::ST_FOUND;
              emit_pos    = 1'b1;
              state_d     = ctas_pkg::FSM_IDLE;
            end else if (is_last) begin
              emit        = 1'b1;
              emit_status = ctas_pkg::ST_NOT_FOUND;
              state_d     = ctas_pkg::FSM_IDLE;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          ctas_pkg::OP_DELETE: begin
            if (hit) begin
              if (is_last) begin
                count_d     = count_m1;
                emit        = 1'b1;
                emit_status = ctas_pkg::ST_DELETED;
                emit_pos    = 1'b1;
                state_d     = ctas_pkg::FSM_IDLE;
              end else begin
                raddr   = last_idx;
                state_d = ctas_pkg::FSM_REPL;
              end
            end else if (is_last) begin
              emit        = 1'b1;
              emit_status = ctas_pkg::ST_NOT_FOUND;
              state_d     = ctas_pkg::FSM_IDLE;
            end else begin
              idx_d = idx_q + IdxW'(1);
            end
          end
          default: begin
            state_d = ctas_pkg::FSM_IDLE;
          end
        endcase
      end
      ctas_pkg::FSM_REPL: begin
        we          = 1'b1;
        waddr       = idx_q;
        wdata       = rdata_q;
        count_d     = count_m1;
        emit        = 1'b1;
        emit_status = ctas_pkg::ST_DELETED;
        emit_pos    = 1'b1;
        emit_data   = rdata_q;
        emit_repl   = 1'b1;
        state_d     = ctas_pkg::FSM_IDLE;
      end
      default: begin
        state_d = ctas_pkg::FSM_IDLE;
      end
    endcase
  end

  assign node     = {{(ctas_pkg::PosW - IdxW){1'b0}}, emit_idx} + ctas_pkg::PosW'(1);
  assign node_lvl = ctas_pkg::level_of(node);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ctas_pkg::FSM_IDLE;
      count_q  <= '0;
      strobe_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    idx_q <= idx_d;
    if (emit) begin
      status_o         <= emit_status;
      tree_level_o     <= emit_pos ? node_lvl : '0;
      level_position_o <= emit_pos ? ctas_pkg::position_of(node, node_lvl) : '0;
      data_value_o     <= emit_data;
      was_replaced_o   <= emit_repl;
      last_result_o    <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

// ===== design/ctas_checker.sv =====
// Port-level checker for the complete tree array store, bound to the top level.
`include "complete_tree_array_store_macros.svh"

module ctas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic [63:0] key_value_i,
  input logic        strobe_o,
  input logic [2:0]  status_o,
  input logic [2:0]  tree_level_o,
  input logic [6:0]  level_position_o,
  input logic [63:0] data_value_o,
  input logic        was_replaced_o,
  input logic        last_result_o
);

  logic insert_acc;
  logic replaced_bad;
  logic insert_bad;

  assign insert_acc   = start && !busy && (opcode_i == ctas_pkg::OP_INSERT);
  assign replaced_bad = strobe_o && was_replaced_o && (status_o != ctas_pkg::ST_DELETED);
  assign insert_bad   = strobe_o && (status_o == ctas_pkg::ST_INSERTED) &&
                        ((tree_level_o == 3'd0) || (level_position_o == 7'd0) ||
                         (data_value_o != 64'd0));

  `CTAS_ASSERT(a_insert_next, insert_acc |=> strobe_o && last_result_o, "insert word late")
  `CTAS_ASSERT(a_done_word, $fell(busy) |-> strobe_o && last_result_o, "no final word")
  `CTAS_ASSERT(a_more_words, strobe_o && !last_result_o |-> busy, "listing stopped early")
  `CTAS_ASSERT_NEVER(a_repl_delete, replaced_bad, "replacement flag outside delete")
  `CTAS_ASSERT_NEVER(a_insert_pos, insert_bad, "inserted word without position")

endmodule

bind complete_tree_array_store ctas_checker u_ctas_checker (.*);
